// ----- design/cts_pkg.sv -----
// shared types and constants for the commit timestamp table
package cts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int TS_W        = 63;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_RECORD = 1'b1;

  typedef logic [TS_W-1:0]  ts_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic mode;
    ts_t  start_ts;
    ts_t  commit_ts;
    ts_t  watermark_in;
  } req_t;

  typedef struct packed {
    ts_t tag;
    ts_t commit;
  } slot_t;

  typedef struct packed {
    ts_t found_commit;
    ts_t watermark_out;
  } rsp_t;

  function automatic idx_t slot_of(input ts_t ts);
    return ts[IDX_W-1:0];
  endfunction

endpackage

// ----- design/cts_eval.sv -----
// result and slot update for one request against the slot it read
module cts_eval (
  input  cts_pkg::req_t  req,
  input  cts_pkg::slot_t slot_rd,
  output cts_pkg::rsp_t  rsp,
  output logic           wr_en,
  output cts_pkg::slot_t slot_wr
);
  import cts_pkg::*;

  logic tag_hit;

  always_comb begin
    tag_hit = (slot_rd.tag == req.start_ts);
    rsp.found_commit  = '0;
    rsp.watermark_out = req.watermark_in;
    wr_en             = 1'b0;
    slot_wr.tag       = req.start_ts;
    slot_wr.commit    = req.commit_ts;
    if (req.mode == MODE_RECORD) begin
      wr_en = 1'b1;
      // evicting a different start raises the watermark
      if (!tag_hit && (slot_rd.commit > req.watermark_in)) begin
        rsp.watermark_out = slot_rd.commit;
      end
    end else if (tag_hit) begin
      rsp.found_commit = slot_rd.commit;
    end
  end

endmodule

// ----- design/commit_timestamp_table.sv -----
// top level of the direct-mapped commit timestamp table
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  mode, start_ts, commit_ts, watermark_in
// out      output     out_valid / out_stall found_commit, watermark_out
//
// one request per cycle while in_stall is low: the slot memory read is
// registered, then evaluated, written back and registered at the output.
// a record followed by a request to the same slot is served by a bypass.
// after reset a clearing pass writes zeros to all TABLE_DEPTH slots, one per
// cycle, and in_stall stays high until it is done.
// out_stall holds the output register and the request behind it.
module commit_timestamp_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         mode,
  input  cts_pkg::ts_t start_ts,
  input  cts_pkg::ts_t commit_ts,
  input  cts_pkg::ts_t watermark_in,
  output logic         out_valid,
  input  logic         out_stall,
  output cts_pkg::ts_t found_commit,
  output cts_pkg::ts_t watermark_out
);
  import cts_pkg::*;

  slot_t mem [TABLE_DEPTH];

  logic  clr_busy;
  idx_t  clr_addr;
  logic  s1_valid;
  req_t  s1_req;
  slot_t rd_data;
  logic  fwd_sel;
  slot_t fwd_data;

  req_t  in_req;
  idx_t  in_idx;
  logic  in_acc;
  logic  s1_move;
  slot_t slot_view;
  rsp_t  rsp;
  logic  ev_wr_en;
  slot_t ev_wr_data;
  logic  wr_en;
  logic  mem_we;
  idx_t  mem_waddr;
  slot_t mem_wdata;
  logic  fwd_hit;

  always_comb begin
    in_req.mode         = mode;
    in_req.start_ts     = start_ts;
    in_req.commit_ts    = commit_ts;
    in_req.watermark_in = watermark_in;
    in_idx              = slot_of(start_ts);
  end

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clr_busy || (s1_valid && !s1_move);
  assign in_acc   = in_valid && !in_stall;

  assign slot_view = fwd_sel ? fwd_data : rd_data;

  cts_eval u_eval (
    .req     (s1_req),
    .slot_rd (slot_view),
    .rsp     (rsp),
    .wr_en   (ev_wr_en),
    .slot_wr (ev_wr_data)
  );

  assign wr_en   = s1_move && ev_wr_en;
  assign fwd_hit = wr_en && (slot_of(s1_req.start_ts) == in_idx);

  always_comb begin
    if (clr_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = slot_of(s1_req.start_ts);
      mem_wdata = ev_wr_data;
    end
  end

  // slot memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == idx_t'(TABLE_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req   <= in_req;
      fwd_sel  <= fwd_hit;
      fwd_data <= ev_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      found_commit  <= rsp.found_commit;
      watermark_out <= rsp.watermark_out;
    end
  end

  // a request right behind a record to its slot sees the new contents
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    fwd_hit && in_acc |=> slot_view == $past(ev_wr_data))
    else $error("bypass data mismatch");

  // nothing is in flight while the table is being cleared
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_valid && !out_valid)
    else $error("request in flight during clearing pass");

  // the reported watermark never falls below the one supplied
  a_wm_mono: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> watermark_out >= $past(s1_req.watermark_in))
    else $error("watermark decreased");

  // a record never reports a found commit
  a_rec_zero: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_req.mode == MODE_RECORD |=> found_commit == '0)
    else $error("record returned a commit");

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the direct-mapped commit timestamp table
module testbench;

  import cts_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 100;
  localparam int MAX_REPORTS   = 100;
  localparam int POOL_SIZE     = 32;
  localparam int RANDOM_ITEMS  = 1070;
  localparam int FLOOD_ITEMS   = 60;
  localparam int STREAM_ITEMS  = 150;
  localparam ts_t TS_MAX       = '1;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic in_valid     = 1'b0;
  logic in_stall;
  logic mode         = MODE_QUERY;
  ts_t  start_ts     = '0;
  ts_t  commit_ts    = '0;
  ts_t  watermark_in = '0;
  logic out_valid;
  logic out_stall    = 1'b0;
  ts_t  found_commit;
  ts_t  watermark_out;

  // shadow copy of the table contents
  ts_t shadow_tag    [TABLE_DEPTH];
  ts_t shadow_commit [TABLE_DEPTH];
  ts_t recent_starts [POOL_SIZE];

  rsp_t awaited_results[$];
  rsp_t oldest_expected;

  bit sender_idle_on   = 1'b0;
  bit receiver_idle_on = 1'b0;
  int long_hold_trigger = 0;
  int long_hold_seen    = 0;
  int hold_left         = 0;

  int cycles        = 0;
  int mismatches    = 0;
  int reports       = 0;
  int records_sent  = 0;
  int queries_sent  = 0;
  int results_seen  = 0;

  commit_timestamp_table DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .start_ts     (start_ts),
    .commit_ts    (commit_ts),
    .watermark_in (watermark_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found_commit (found_commit),
    .watermark_out(watermark_out)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $time, cycles,
               awaited_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: short random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (long_hold_trigger != long_hold_seen) begin
      long_hold_seen <= long_hold_trigger;
      hold_left      <= LONG_HOLD - 1;
      out_stall      <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void note_mismatch(string what, ts_t want, ts_t got);
    mismatches++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t mismatch on %s: expected %h actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t unexpected result: expected none actual found %h watermark %h",
                   $time, found_commit, watermark_out);
        end
      end else begin
        oldest_expected = awaited_results.pop_front();
        if (found_commit !== oldest_expected.found_commit)
          note_mismatch("found_commit", oldest_expected.found_commit, found_commit);
        if (watermark_out !== oldest_expected.watermark_out)
          note_mismatch("watermark_out", oldest_expected.watermark_out, watermark_out);
      end
    end
  end

  // lookup or record against the shadow table, queue the answer
  function automatic void predict_access(logic m, ts_t s, ts_t c, ts_t w);
    idx_t i;
    rsp_t r;
    i = s[IDX_W-1:0];
    r.found_commit  = '0;
    r.watermark_out = w;
    if (m == MODE_RECORD) begin
      if (shadow_tag[i] != s && shadow_commit[i] > w) r.watermark_out = shadow_commit[i];
      shadow_tag[i]    = s;
      shadow_commit[i] = c;
      records_sent++;
    end else begin
      if (shadow_tag[i] == s) r.found_commit = shadow_commit[i];
      queries_sent++;
    end
    awaited_results.push_back(r);
  endfunction

  task automatic send_request(logic m, ts_t s, ts_t c, ts_t w);
    @(negedge clk);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    start_ts     <= s;
    commit_ts    <= c;
    watermark_in <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_access(m, s, c, w);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic ts_t rand_ts();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TS_W-1:0];
  endfunction

  function automatic ts_t rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TS_MAX;
      2:       return ts_t'($urandom_range(0, 100));
      default: return rand_ts();
    endcase
  endfunction

  // mostly reuse and alias recent starts so queries hit and records evict
  task automatic send_random_request(bit hot);
    logic m;
    ts_t  s;
    ts_t  c;
    ts_t  w;
    ts_t  hi;
    idx_t i;
    m  = $urandom_range(0, 1) ? MODE_RECORD : MODE_QUERY;
    hi = rand_ts();
    case (hot ? 6 : $urandom_range(0, 9))
      0, 1, 2, 3: s = recent_starts[$urandom_range(0, POOL_SIZE - 1)];
      4, 5: begin
        s = recent_starts[$urandom_range(0, POOL_SIZE - 1)];
        s = {hi[TS_W-1:IDX_W], s[IDX_W-1:0]};
      end
      6, 7: s = {hi[TS_W-1:IDX_W], idx_t'($urandom_range(0, 3))};
      8: s = rand_ts();
      default: s = rand_value();
    endcase
    if (hot && $urandom_range(0, 1)) s = recent_starts[$urandom_range(0, 3)];
    i = s[IDX_W-1:0];
    c = rand_value();
    case ($urandom_range(0, 5))
      0:       w = shadow_commit[i];
      1:       w = shadow_commit[i] - 1;
      2:       w = shadow_commit[i] + 1;
      default: w = rand_value();
    endcase
    if (m == MODE_RECORD) recent_starts[$urandom_range(0, POOL_SIZE - 1)] = s;
    send_request(m, s, c, w);
  endtask

  task automatic test_cleared_table();
    send_request(MODE_QUERY, '0, '0, '0);
    send_request(MODE_QUERY, TS_MAX, TS_MAX, '0);
    send_request(MODE_QUERY, ts_t'(1), '0, TS_MAX);
    send_request(MODE_QUERY, ts_t'(TABLE_DEPTH), TS_MAX, ts_t'(42));
    go_quiet();
  endtask

  task automatic test_record_paths();
    ts_t alias_max;
    alias_max = TS_MAX;
    alias_max[TS_W-1] = 1'b0;
    send_request(MODE_RECORD, TS_MAX, TS_MAX, '0);
    send_request(MODE_QUERY,  TS_MAX, '0, '0);
    // same start: commit replaced, watermark passes through
    send_request(MODE_RECORD, TS_MAX, ts_t'(5), ts_t'(7));
    send_request(MODE_QUERY,  TS_MAX, '0, '0);
    // different start in the same slot evicts the old commit
    send_request(MODE_RECORD, alias_max, ts_t'(9), ts_t'(4));
    send_request(MODE_RECORD, TS_MAX, ts_t'(1), ts_t'(9));
    send_request(MODE_RECORD, alias_max, '0, '0);
    send_request(MODE_QUERY,  TS_MAX, '0, '0);
    send_request(MODE_QUERY,  alias_max, TS_MAX, TS_MAX);
    send_request(MODE_RECORD, '0, ts_t'(123), '0);
    send_request(MODE_QUERY,  '0, '0, '0);
    send_request(MODE_RECORD, ts_t'(TABLE_DEPTH), ts_t'(77), TS_MAX);
    send_request(MODE_QUERY,  ts_t'(TABLE_DEPTH), '0, '0);
    send_request(MODE_QUERY,  '0, '0, '0);
    send_request(MODE_RECORD, '0, TS_MAX, ts_t'(76));
    send_request(MODE_RECORD, ts_t'(2 * TABLE_DEPTH), ts_t'(3), '0);
    send_request(MODE_QUERY,  ts_t'(2 * TABLE_DEPTH), '0, ts_t'(3));
    send_request(MODE_RECORD, ts_t'(1), TS_MAX, TS_MAX);
    send_request(MODE_QUERY,  ts_t'(1), '0, '0);
    go_quiet();
  endtask

  task automatic test_random_traffic();
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    repeat (RANDOM_ITEMS) send_random_request(1'b0);
    go_quiet();
  endtask

  // receiver holds off long enough for the pipeline to back up into in_stall
  task automatic test_backpressure();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    @(posedge clk);
    long_hold_trigger++;
    repeat (FLOOD_ITEMS) send_random_request(1'b1);
    go_quiet();
    wait_for_drain();
  endtask

  task automatic test_streaming();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    repeat (STREAM_ITEMS) send_random_request($urandom_range(0, 2) == 0);
    go_quiet();
  endtask

  initial begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      shadow_tag[k]    = '0;
      shadow_commit[k] = '0;
    end
    for (int k = 0; k < POOL_SIZE; k++)
      recent_starts[k] = (k < 4) ? ts_t'(k) : rand_ts();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_cleared_table();
    test_record_paths();
    test_random_traffic();
    test_backpressure();
    test_streaming();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0t %0d results never arrived", $time, awaited_results.size());
    end

    $display("run covered %0d records and %0d queries, %0d results checked, %0d mismatches",
             records_sent, queries_sent, results_seen, mismatches);
    $display("traffic mixed hits, aliased evictions and watermark edges under idle and stall");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
